// File: rtl/core/mwbp_pkg.sv
// Shared types, constants and helpers of the mesh warp bilinear projector.
// No dependencies; every other file of the block but mwbp_ram imports this package.
`timescale 1ns / 1ps

package mwbp_pkg;

   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   // Cell and node indexes are 8 bits wide, enough for up to 256 columns or rows.
   localparam int IDX_W       = 8;
   localparam int DIM_W       = IDX_W + 1;
   localparam int COORD_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int INV_W       = 32;
   localparam int MESH_DIM_W  = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_VALIDATE = 2'd1,
      CMD_PROJECT  = 2'd2
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_LEFT     = 3'd0,
      CSR_ORIGIN_TOP      = 3'd1,
      CSR_CELL_WIDTH      = 3'd2,
      CSR_CELL_HEIGHT     = 3'd3,
      CSR_INV_CELL_WIDTH  = 3'd4,
      CSR_INV_CELL_HEIGHT = 3'd5,
      CSR_MESH_COLS       = 3'd6,
      CSR_MESH_ROWS       = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic [5:0]                 node_col;
      logic [5:0]                 node_row;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  mapped_x;
      logic signed [COORD_W-1:0]  mapped_y;
      logic                       success;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  origin_left;
      logic signed [COORD_W-1:0]  origin_top;
      logic [INV_W-1:0]           inv_cell_width;
      logic [INV_W-1:0]           inv_cell_height;
      logic [MESH_DIM_W-1:0]      mesh_cols;
      logic [MESH_DIM_W-1:0]      mesh_rows;
   } cfg_type;

   typedef enum logic [1:0] {
      TASK_WRITE,
      TASK_VALIDATE,
      TASK_PROJECT,
      TASK_NONE
   } task_kind_type;

   // Classified command handed from front to back.
   // Write: col/row is the node. Project: col/row is the upper left corner,
   // col_next/row_next the right and lower corners.
   typedef struct packed {
      task_kind_type              kind;
      logic                       ok;
      logic [IDX_W-1:0]           col;
      logic [IDX_W-1:0]           row;
      logic [IDX_W-1:0]           col_next;
      logic [IDX_W-1:0]           row_next;
      logic [FRAC_W-1:0]          frac_u;
      logic [FRAC_W-1:0]          frac_v;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
   } task_type;

   // One node of the grid store.
   typedef struct packed {
      logic                       valid;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  x;
   } node_word_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WRITE,
      BK_VALIDATE,
      BK_PROJ_READ,
      BK_PROJ_LERP,
      BK_DONE
   } back_state_type;

   // Grid size in use: at least three, at most the built size.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [MESH_DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] w;
      w = DIM_W'(v);
      if (w < DIM_W'(3)) return DIM_W'(3);
      if (w > maxv) return maxv;
      return w;
   endfunction

endpackage

// File: rtl/core/mesh_warp_bilinear_projector_top.sv
// Top level of the mesh warp bilinear projector: configuration registers,
// front end, task queue and back end. Depends on mwbp_pkg, mwbp_front,
// mwbp_queue and mwbp_back.
//
//   channel   direction  handshake            payload
//   req_      in         push / full          req_type (command, node, coords)
//   rsp_      out        empty / pop          rsp_type (mapped x/y, success)
//   csr_      in         valid / ready        csr_index, csr_data
//
// The front end passes each request through its capture, offset and scale
// stages; it keeps taking requests while the back end works, until the
// two-entry queue fills. Back end: project reads four corners over the single
// store read port, then makes six passes of one shared multiplier; validate
// checks every node in use in turn.
// After reset a clearing pass over all MAX_COLS*MAX_ROWS nodes (4096 default)
// holds req_full high; configuration writes are taken throughout.
// A result waits in an output register; while it is not popped the back end
// holds its next result and the queue fills behind it.
`timescale 1ns / 1ps

module mesh_warp_bilinear_projector_top import mwbp_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   logic     clearing;
   logic     q_push, q_full, q_pop, q_empty;
   task_type q_in, q_out;

   assign csr_ready = 1'b1;

   // configuration registers; spacing registers are accepted but not stored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_left     <= '0;
         cfg_ff.origin_top      <= '0;
         cfg_ff.inv_cell_width  <= INV_W'(65536);
         cfg_ff.inv_cell_height <= INV_W'(65536);
         cfg_ff.mesh_cols       <= MESH_DIM_W'(3);
         cfg_ff.mesh_rows       <= MESH_DIM_W'(3);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_LEFT:     cfg_ff.origin_left     <= csr_data;
            CSR_ORIGIN_TOP:      cfg_ff.origin_top      <= csr_data;
            CSR_INV_CELL_WIDTH:  cfg_ff.inv_cell_width  <= csr_data;
            CSR_INV_CELL_HEIGHT: cfg_ff.inv_cell_height <= csr_data;
            CSR_MESH_COLS:       cfg_ff.mesh_cols       <= csr_data[MESH_DIM_W-1:0];
            CSR_MESH_ROWS:       cfg_ff.mesh_rows       <= csr_data[MESH_DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mwbp_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .clearing (clearing),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_full   (q_full)
   );

   mwbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pdata (q_in),
      .full  (q_full),
      .pop   (q_pop),
      .qdata (q_out),
      .empty (q_empty)
   );

   mwbp_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/mwbp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mwbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: rtl/core/mwbp_queue.sv
// Short task queue between front and back of the projector.
// Depends on mwbp_pkg for the task type.
`timescale 1ns / 1ps

module mwbp_queue import mwbp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type pdata,
   output logic     full,
   input  logic     pop,
   output task_type qdata,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   task_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign qdata   = entry_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= pdata;
      end
   end

endmodule

// File: rtl/core/mwbp_front.sv
// Front end: takes requests, locates the source cell of projections and
// classifies every command into a task for the queue. Depends on mwbp_pkg.
`timescale 1ns / 1ps

module mwbp_front import mwbp_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     clearing,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output logic     q_push,
   output task_type q_data,
   input  logic     q_full
);

   localparam int PROD_W = 2 * INV_W;

   // stage 1: captured request
   logic    s1_valid_ff;
   req_type s1_req_ff;
   // stage 2: offsets from the grid origin
   logic             s2_valid_ff;
   req_type          s2_req_ff;
   logic [INV_W-1:0] s2_dx_ff, s2_dy_ff;
   logic             s2_negx_ff, s2_negy_ff;
   // stage 3: scaled offsets
   logic              s3_valid_ff;
   req_type           s3_req_ff;
   logic [PROD_W-1:0] s3_px_ff, s3_py_ff;
   logic              s3_failx_ff, s3_faily_ff;

   logic              stall, accept;
   logic signed [COORD_W:0] dx_in, dy_in;
   logic [PROD_W-1:0] px_in, py_in;
   logic [DIM_W-1:0]  cols, rows;
   logic [PROD_W-25:0] idx_x, idx_y;
   logic [IDX_W-1:0]  lc, tr;
   logic              in_x, in_y;

   assign stall    = s3_valid_ff && q_full;
   assign req_full = stall || clearing;
   assign accept   = req_push && !req_full;

   // offsets; rows advance as y decreases
   assign dx_in = {s1_req_ff.coord_x[COORD_W-1], s1_req_ff.coord_x}
                - {cfg.origin_left[COORD_W-1], cfg.origin_left};
   assign dy_in = {cfg.origin_top[COORD_W-1], cfg.origin_top}
                - {s1_req_ff.coord_y[COORD_W-1], s1_req_ff.coord_y};

   // scale by the reciprocal spacing; a negative offset scales to zero
   assign px_in = s2_negx_ff ? '0 : s2_dx_ff * cfg.inv_cell_width;
   assign py_in = s2_negy_ff ? '0 : s2_dy_ff * cfg.inv_cell_height;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_req_ff   <= req_data;
         s2_req_ff   <= s1_req_ff;
         s2_dx_ff    <= dx_in[INV_W-1:0];
         s2_dy_ff    <= dy_in[INV_W-1:0];
         s2_negx_ff  <= dx_in[COORD_W];
         s2_negy_ff  <= dy_in[COORD_W];
         s3_req_ff   <= s2_req_ff;
         s3_px_ff    <= px_in;
         s3_py_ff    <= py_in;
         s3_failx_ff <= s2_negx_ff && (cfg.inv_cell_width != '0);
         s3_faily_ff <= s2_negy_ff && (cfg.inv_cell_height != '0);
      end
   end

   // cell index is the product over 2^24, the fraction the 16 bits below it
   assign cols  = eff_dim(cfg.mesh_cols, DIM_W'(MAX_COLS));
   assign rows  = eff_dim(cfg.mesh_rows, DIM_W'(MAX_ROWS));
   assign idx_x = s3_px_ff[PROD_W-1:24];
   assign idx_y = s3_py_ff[PROD_W-1:24];
   assign in_x  = !s3_failx_ff && (idx_x < (PROD_W-24)'(cols));
   assign in_y  = !s3_faily_ff && (idx_y < (PROD_W-24)'(rows));
   assign lc    = idx_x[IDX_W-1:0];
   assign tr    = idx_y[IDX_W-1:0];

   // classify into a task
   always_comb begin
      q_data          = '0;
      q_data.coord_x  = s3_req_ff.coord_x;
      q_data.coord_y  = s3_req_ff.coord_y;
      q_data.frac_u   = s3_px_ff[23:8];
      q_data.frac_v   = s3_py_ff[23:8];
      unique case (s3_req_ff.command)
         CMD_WRITE: begin
            q_data.kind = TASK_WRITE;
            q_data.col  = IDX_W'(s3_req_ff.node_col);
            q_data.row  = IDX_W'(s3_req_ff.node_row);
            q_data.ok   = (DIM_W'(s3_req_ff.node_col) < DIM_W'(MAX_COLS))
                       && (DIM_W'(s3_req_ff.node_row) < DIM_W'(MAX_ROWS));
         end
         CMD_VALIDATE: begin
            q_data.kind = TASK_VALIDATE;
            q_data.ok   = 1'b1;
         end
         CMD_PROJECT: begin
            q_data.kind     = TASK_PROJECT;
            q_data.ok       = in_x && in_y;
            q_data.col      = lc;
            q_data.row      = tr;
            // last column or row: the far corner is the node itself
            q_data.col_next = (DIM_W'(lc) + DIM_W'(1) == cols) ? lc : lc + IDX_W'(1);
            q_data.row_next = (DIM_W'(tr) + DIM_W'(1) == rows) ? tr : tr + IDX_W'(1);
         end
         default: begin
            q_data.kind = TASK_NONE;
         end
      endcase
   end

   assign q_push = s3_valid_ff && !q_full;

endmodule

// File: rtl/core/mwbp_back.sv
// Back end: owns the node store, clears it after reset, and carries out
// write, validate and project tasks. Depends on mwbp_pkg and mwbp_ram.
`timescale 1ns / 1ps

module mwbp_back import mwbp_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   output logic     q_pop,
   input  task_type q_data,
   output logic     clearing,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int NODE_COUNT = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int WORD_W     = $bits(node_word_type);
   localparam int MUL_W      = COORD_W + FRAC_W + 2;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

   back_state_type state_ff, state_in;
   task_type       task_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [2:0]     step_ff;
   logic [IDX_W-1:0] vr_ff, vc_ff;
   node_word_type  w0_ff, w1_ff, w2_ff, w3_ff;
   logic signed [COORD_W-1:0] nb_l_ff, nb_r_ff, nb_t_ff, nb_b_ff;
   logic signed [MUL_W-1:0]   prod_ff;
   logic signed [COORD_W-1:0] base_ff;
   logic signed [COORD_W-1:0] topx_ff, botx_ff, topy_ff, boty_ff, outx_ff;
   rsp_type        res_ff, out_ff;
   logic           out_valid_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   node_word_type     ram_wdata, ram_rdata;

   logic [DIM_W-1:0] cols, rows;
   logic             vc_last, vr_last, node_ok, corners_ok, out_free, out_load;
   logic [IDX_W-1:0] lcol, rcol, trow, brow;
   logic [FRAC_W-1:0]         lerp_f;
   logic signed [COORD_W-1:0] lerp_a, lerp_b, lerp_sum;
   logic signed [COORD_W:0]   lerp_diff;
   logic signed [MUL_W-1:0]   mul_c, rnd;

   function automatic logic [ADDR_W-1:0] node_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   function automatic logic opposite(input logic signed [COORD_W:0] p,
                                     input logic signed [COORD_W:0] q);
      logic p_pos, p_neg, q_pos, q_neg;
      p_neg = p[COORD_W];
      q_neg = q[COORD_W];
      p_pos = !p_neg && (p != '0);
      q_pos = !q_neg && (q != '0);
      return (p_pos && q_neg) || (p_neg && q_pos);
   endfunction

   mwbp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign cols     = eff_dim(cfg.mesh_cols, DIM_W'(MAX_COLS));
   assign rows     = eff_dim(cfg.mesh_rows, DIM_W'(MAX_ROWS));
   assign clearing = (state_ff == BK_CLEAR);
   assign out_free = !out_valid_ff || rsp_pop;

   // neighbors of the node under validation; edges fall back to the node
   assign vc_last = (DIM_W'(vc_ff) + DIM_W'(1) == cols);
   assign vr_last = (DIM_W'(vr_ff) + DIM_W'(1) == rows);
   assign lcol    = (vc_ff == '0) ? vc_ff : vc_ff - IDX_W'(1);
   assign rcol    = vc_last ? vc_ff : vc_ff + IDX_W'(1);
   assign trow    = (vr_ff == '0) ? vr_ff : vr_ff - IDX_W'(1);
   assign brow    = vr_last ? vr_ff : vr_ff + IDX_W'(1);

   // monotone test of the node against its captured neighbors
   assign node_ok = !(opposite({nb_r_ff[COORD_W-1], nb_r_ff} - {w0_ff.x[COORD_W-1], w0_ff.x},
                               {w0_ff.x[COORD_W-1], w0_ff.x} - {nb_l_ff[COORD_W-1], nb_l_ff})
                   || opposite({nb_t_ff[COORD_W-1], nb_t_ff} - {w0_ff.y[COORD_W-1], w0_ff.y},
                               {w0_ff.y[COORD_W-1], w0_ff.y} - {nb_b_ff[COORD_W-1], nb_b_ff}));

   assign corners_ok = w0_ff.valid && w1_ff.valid && w2_ff.valid && w3_ff.valid;

   // shared interpolation multiplier: operands per step
   always_comb begin
      case (step_ff)
         3'd0:    begin lerp_f = task_ff.frac_u; lerp_a = w0_ff.x; lerp_b = w1_ff.x; end
         3'd1:    begin lerp_f = task_ff.frac_u; lerp_a = w2_ff.x; lerp_b = w3_ff.x; end
         3'd2:    begin lerp_f = task_ff.frac_u; lerp_a = w0_ff.y; lerp_b = w1_ff.y; end
         3'd3:    begin lerp_f = task_ff.frac_u; lerp_a = w2_ff.y; lerp_b = w3_ff.y; end
         3'd4:    begin lerp_f = task_ff.frac_v; lerp_a = topx_ff; lerp_b = botx_ff; end
         default: begin lerp_f = task_ff.frac_v; lerp_a = topy_ff; lerp_b = boty_ff; end
      endcase
   end

   assign lerp_diff = {lerp_b[COORD_W-1], lerp_b} - {lerp_a[COORD_W-1], lerp_a};
   assign mul_c     = $signed({1'b0, lerp_f}) * lerp_diff;
   // round half up, then add to the base; the sum stays between the operands
   assign rnd       = (prod_ff + MUL_W'(32768)) >>> FRAC_W;
   assign lerp_sum  = base_ff + rnd[COORD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == LAST_ADDR) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!q_empty) begin
               unique case (q_data.kind)
                  TASK_WRITE:    state_in = BK_WRITE;
                  TASK_VALIDATE: state_in = BK_VALIDATE;
                  TASK_PROJECT:  state_in = q_data.ok ? BK_PROJ_READ : BK_DONE;
                  default:       state_in = BK_DONE;
               endcase
            end
         end
         BK_WRITE: begin
            state_in = BK_DONE;
         end
         BK_VALIDATE: begin
            if (step_ff == 3'd6 && vc_last && vr_last) state_in = BK_DONE;
         end
         BK_PROJ_READ: begin
            if (step_ff == 3'd5) state_in = corners_ok ? BK_PROJ_LERP : BK_DONE;
         end
         BK_PROJ_LERP: begin
            if (step_ff == 3'd6) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // outputs: queue pop, store ports, result load
   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = node_addr(task_ff.row, task_ff.col);
      ram_wdata = '{valid: 1'b1, y: task_ff.coord_y, x: task_ff.coord_x};
      ram_raddr = node_addr(vr_ff, vc_ff);
      out_load  = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         BK_IDLE: begin
            q_pop = !q_empty;
         end
         BK_WRITE: begin
            ram_we = task_ff.ok;
         end
         BK_VALIDATE: begin
            case (step_ff)
               3'd1:    ram_raddr = node_addr(vr_ff, lcol);
               3'd2:    ram_raddr = node_addr(vr_ff, rcol);
               3'd3:    ram_raddr = node_addr(trow, vc_ff);
               3'd4:    ram_raddr = node_addr(brow, vc_ff);
               default: ram_raddr = node_addr(vr_ff, vc_ff);
            endcase
            // an invalid node stays as it is
            ram_we    = (step_ff == 3'd6) && w0_ff.valid;
            ram_waddr = node_addr(vr_ff, vc_ff);
            ram_wdata = '{valid: node_ok, y: w0_ff.y, x: w0_ff.x};
         end
         BK_PROJ_READ: begin
            case (step_ff)
               3'd0:    ram_raddr = node_addr(task_ff.row, task_ff.col);
               3'd1:    ram_raddr = node_addr(task_ff.row, task_ff.col_next);
               3'd2:    ram_raddr = node_addr(task_ff.row_next, task_ff.col);
               default: ram_raddr = node_addr(task_ff.row_next, task_ff.col_next);
            endcase
         end
         BK_PROJ_LERP: begin
         end
         BK_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   // task datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            task_ff         <= q_data;
            step_ff         <= '0;
            vr_ff           <= '0;
            vc_ff           <= '0;
            res_ff          <= '{mapped_x: '0, mapped_y: '0,
                                 success: (q_data.kind == TASK_WRITE && q_data.ok)
                                       || (q_data.kind == TASK_VALIDATE)};
         end
         BK_VALIDATE: begin
            case (step_ff)
               3'd1: w0_ff   <= ram_rdata;
               3'd2: nb_l_ff <= ram_rdata.x;
               3'd3: nb_r_ff <= ram_rdata.x;
               3'd4: nb_t_ff <= ram_rdata.y;
               3'd5: nb_b_ff <= ram_rdata.y;
               default: begin
               end
            endcase
            if (step_ff == 3'd6) begin
               step_ff <= '0;
               if (vc_last) begin
                  vc_ff <= '0;
                  vr_ff <= vr_ff + IDX_W'(1);
               end else begin
                  vc_ff <= vc_ff + IDX_W'(1);
               end
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
         BK_PROJ_READ: begin
            case (step_ff)
               3'd1: w0_ff <= ram_rdata;
               3'd2: w1_ff <= ram_rdata;
               3'd3: w2_ff <= ram_rdata;
               3'd4: w3_ff <= ram_rdata;
               default: begin
               end
            endcase
            step_ff <= (step_ff == 3'd5) ? 3'd0 : step_ff + 3'd1;
         end
         BK_PROJ_LERP: begin
            prod_ff <= mul_c;
            base_ff <= lerp_a;
            case (step_ff)
               3'd1: topx_ff <= lerp_sum;
               3'd2: botx_ff <= lerp_sum;
               3'd3: topy_ff <= lerp_sum;
               3'd4: boty_ff <= lerp_sum;
               3'd5: outx_ff <= lerp_sum;
               3'd6: begin
                  res_ff.mapped_x <= outx_ff;
                  res_ff.mapped_y <= lerp_sum;
                  res_ff.success  <= 1'b1;
               end
               default: begin
               end
            endcase
            step_ff <= step_ff + 3'd1;
         end
         default: begin
         end
      endcase
   end

   // result register toward the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) out_ff <= res_ff;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // no task is taken while the store is being cleared
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("task taken during clearing pass");

   // validation rewrites only nodes that were valid
   a_val_write_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_VALIDATE && ram_we) |-> w0_ff.valid)
      else $error("validation wrote an invalid node");

   // interpolation sequencer stays within its seven steps
   a_lerp_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_PROJ_LERP) |-> (step_ff <= 3'd6))
      else $error("interpolation step out of range");

   // reset always restarts the clearing pass from the first node
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (state_ff == BK_CLEAR && clr_ff == '0 && !out_valid_ff))
      else $error("reset did not restart clearing");

endmodule
